// ===== hdl/cepc_pkg.sv =====
// Shared constants and types for the cross-erosion pixel counter.
package cepc_pkg;

  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = 15;

  localparam logic [CHAR_W-1:0] SET_THRESHOLD = 8'd42;   // code of '*'
  localparam logic [CNT_W-1:0]  COUNT_MAX     = 15'h7FFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  // Position flags of the cell held in the update stage
  typedef struct packed {
    logic cur;      // cell is set
    logic r_ge1;
    logic r_ge2;
    logic r_last;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
  } cepc_cell_t;

endpackage

// ===== hdl/cross_erosion_pixel_counter_top.sv =====
// Cross-erosion pixel counter: streaming line-store erosion counter, top level.
//
// Cells arrive in raster order, one character per transfer; a cell is set
// when its code is above 42 ('*'). Per frame of row_count x col_count cells
// the block counts set cells whose in-grid up/down/left/right neighbors are
// all set (neighbors off the grid count as set) and, after the transfer of the
// frame's last cell, delivers the count (saturating at 32767) one transfer
// on the result channel, then starts the next frame from zero. Throughput
// is one cell per clock unless the input stalls: each cell enters a read
// stage that fetches the line-store entry of the next column from a
// single-port-read memory, and the registered cell then reaches an update
// stage that judges the cell above and writes the column entry back. A
// same-cycle write to the entry being read is forwarded, and for a
// one-column grid the written entry feeds the next cell directly. The count
// is registered in the output register when the frame's last cell leaves
// the update stage. The input stalls only when a frame result is ready
// while the previous result still waits in the output register. The line
// store needs no clearing pass after reset: no entry is used before the
// current frame has written it. Writing a configuration register abandons
// the frame in progress; write only while the block is idle. Counts of zero
// act as one, counts above MAX_ROWS / MAX_COLS act as those limits.
module cross_erosion_pixel_counter_top #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [cepc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cepc_pkg::CFG_W-1:0]      cfg_wdata,
  // cell stream
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cepc_pkg::CHAR_W-1:0]     in_cell_char,
  // result stream
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cepc_pkg::CNT_W-1:0]      out_cross_count
);
  import cepc_pkg::*;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // ---------------------------------------------------------------------
  // Configuration: kept as last valid index (clamped count minus one)
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] row_last_r, row_last_nxt;
  logic [COL_W-1:0] col_last_r, col_last_nxt;

  always_comb begin
    row_last_nxt = row_last_r;
    col_last_nxt = col_last_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROW_COUNT: begin
          if (cfg_wdata == '0)
            row_last_nxt = '0;
          else if (32'(cfg_wdata) > MAX_ROWS)
            row_last_nxt = ROW_W'(MAX_ROWS - 1);
          else
            row_last_nxt = ROW_W'(32'(cfg_wdata) - 32'd1);
        end
        REG_COL_COUNT: begin
          if (cfg_wdata == '0)
            col_last_nxt = '0;
          else if (32'(cfg_wdata) > MAX_COLS)
            col_last_nxt = COL_W'(MAX_COLS - 1);
          else
            col_last_nxt = COL_W'(32'(cfg_wdata) - 32'd1);
        end
        default: begin
          row_last_nxt = row_last_r;
          col_last_nxt = col_last_r;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------
  logic             s1_valid_r;
  cepc_cell_t       s1_cell_r;
  logic [COL_W-1:0] s1_col_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_count_r;

  logic s1_frame_end;
  logic s1_stall;
  logic s1_fire;
  logic in_fire;

  assign s1_frame_end = s1_cell_r.r_last && s1_cell_r.c_last;
  // only a frame result that cannot be placed holds the pipeline
  assign s1_stall = s1_valid_r && s1_frame_end && out_valid_r && !out_ready;
  assign s1_fire  = s1_valid_r && !s1_stall;
  assign in_ready = !s1_stall;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Read stage: raster position and line-store read of the next column
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] rd_addr;
  cepc_cell_t       cell_in;

  always_comb begin
    cell_in.cur    = (in_cell_char > SET_THRESHOLD);
    cell_in.r_ge1  = (row_r != '0);
    cell_in.r_ge2  = (32'(row_r) >= 32'd2);
    cell_in.r_last = (row_r == row_last_r);
    cell_in.c_ge1  = (col_r != '0);
    cell_in.c_ge2  = (32'(col_r) >= 32'd2);
    cell_in.c_last = (col_r == col_last_r);
  end

  // column of the cell that follows this one
  assign rd_addr = cell_in.c_last ? '0 : COL_W'(col_r + 1'b1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr_en) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_fire) begin
      col_nxt = rd_addr;
      if (cell_in.c_last)
        row_nxt = cell_in.r_last ? '0 : ROW_W'(row_r + 1'b1);
    end
  end

  // ---------------------------------------------------------------------
  // Line store: bit 0 = latest row's cell in the column, bit 1 = row before
  // ---------------------------------------------------------------------
  logic [1:0]       line_mem [MAX_COLS];
  logic [1:0]       rd_q_r;
  logic             byp_r;
  logic [1:0]       byp_data_r;
  logic             wr_en;
  logic [1:0]       wr_data;
  logic [1:0]       rd_entry;

  always_ff @(posedge clk) begin
    if (wr_en)
      line_mem[s1_col_r] <= wr_data;
    if (in_fire)
      rd_q_r <= line_mem[rd_addr];
  end

  // forward a write that lands on the entry read in the same cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_r      <= wr_en && (s1_col_r == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_entry = byp_r ? byp_data_r : rd_q_r;

  // ---------------------------------------------------------------------
  // Update stage: judge cells, write column entry back, keep the count
  // ---------------------------------------------------------------------
  logic [1:0]       ent_r;       // entry of the column in this stage
  logic             above_l_r;   // cell one row up, one column left
  logic [1:0]       win_r, win_nxt;  // bit 0 = cell to the left, bit 1 = two left
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             inc_above;   // cell one row up
  logic             inc_left;    // cell to the left, last row only
  logic             inc_self;    // frame's last cell
  logic [CNT_W:0]   cnt_sum;

  assign wr_en   = s1_fire;
  assign wr_data = {ent_r[0], s1_cell_r.cur};

  always_comb begin
    inc_above = s1_cell_r.r_ge1 && ent_r[0] && s1_cell_r.cur
              && (!s1_cell_r.r_ge2 || ent_r[1])
              && (!s1_cell_r.c_ge1 || above_l_r)
              && (s1_cell_r.c_last || rd_entry[0]);
    inc_left  = s1_cell_r.r_last && s1_cell_r.c_ge1 && win_r[0] && s1_cell_r.cur
              && (!s1_cell_r.c_ge2 || win_r[1])
              && (!s1_cell_r.r_ge1 || above_l_r);
    inc_self  = s1_frame_end && s1_cell_r.cur
              && (!s1_cell_r.c_ge1 || win_r[0])
              && (!s1_cell_r.r_ge1 || ent_r[0]);
    cnt_sum   = (CNT_W+1)'(count_r) + (CNT_W+1)'(inc_above)
              + (CNT_W+1)'(inc_left) + (CNT_W+1)'(inc_self);
  end

  always_comb begin
    count_nxt = count_r;
    win_nxt   = win_r;
    if (cfg_wr_en) begin
      count_nxt = '0;
      win_nxt   = '0;
    end else if (s1_fire) begin
      if (s1_frame_end) begin
        count_nxt = '0;
        win_nxt   = '0;
      end else begin
        count_nxt = (cnt_sum > (CNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[CNT_W-1:0];
        win_nxt   = {win_r[0], s1_cell_r.cur};
      end
    end
  end

  // entry and upper-left cell handed to the next cell
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      above_l_r <= ent_r[0];
      // one-column grid: next cell reuses the entry just written
      if (s1_cell_r.c_last && (s1_col_r == '0))
        ent_r <= wr_data;
      else
        ent_r <= rd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cell_r <= cell_in;
      s1_col_r  <= col_r;
    end
    if (s1_fire && s1_frame_end)
      out_count_r <= (cnt_sum > (CNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : cnt_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_last_r  <= '0;
      col_last_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      count_r     <= '0;
      win_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_last_r <= row_last_nxt;
      col_last_r <= col_last_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      count_r    <= count_nxt;
      win_r      <= win_nxt;
      if (in_fire)
        s1_valid_r <= 1'b1;
      else if (s1_fire)
        s1_valid_r <= 1'b0;
      if (s1_fire && s1_frame_end)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cross_count = out_count_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && s1_valid_r))
    else $error("input stalled without a waiting result");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_frame_end && !cfg_wr_en) |=> (out_valid_r && count_r == '0 && win_r == '0))
    else $error("frame end did not emit and clear");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= col_last_r)
    else $error("column position beyond configured width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= row_last_r)
    else $error("row position beyond configured height");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted cell missing from update stage");

endmodule

// ===== tb/sv/cross_erosion_pixel_counter_checker.sv =====
// Scoreboard for the cross-erosion pixel counter: tracks config, predicts frame counts, checks results.
`timescale 1ns / 1ps

module cross_erosion_pixel_counter_checker #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [cepc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cepc_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [cepc_pkg::CHAR_W-1:0]     in_cell_char,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [cepc_pkg::CNT_W-1:0]      out_cross_count,
  output int                              error_count,
  output int                              pending_count,
  output int                              results_checked
);
  import cepc_pkg::*;

  // Shadow of the block's frame state
  logic [1:0]       col_hist [MAX_COLS];  // per column: bit 0 latest row, bit 1 row before
  logic [2:0]       row_hist;             // last three cells received, newest in bit 0
  int unsigned      pos_row;
  int unsigned      pos_col;
  logic [CNT_W-1:0] frame_tally;
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;

  logic [CNT_W-1:0] expected_counts [$];

  function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void restart_frame();
    pos_row     = 0;
    pos_col     = 0;
    frame_tally = '0;
    row_hist    = '0;
  endfunction

  function automatic void tally_cross(input logic center, input logic up, input logic down,
                                      input logic left, input logic right);
    if (center && up && down && left && right && frame_tally < COUNT_MAX)
      frame_tally = frame_tally + 1'b1;
  endfunction

  // Consume one cell; returns 1 with the frame count when the cell closes a frame.
  function automatic bit erode_cell(input logic [CHAR_W-1:0] ch, output logic [CNT_W-1:0] cnt);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    logic        cur;
    logic        center;
    logic        up;
    logic        left;
    logic        right;
    logic [1:0]  old;
    cnt  = '0;
    rows = fit_dim(rows_reg, MAX_ROWS);
    cols = fit_dim(cols_reg, MAX_COLS);
    r    = pos_row;
    c    = pos_col;
    if (r >= rows || c >= cols) begin
      restart_frame();
      r = 0;
      c = 0;
    end
    cur = (ch > SET_THRESHOLD);
    old = col_hist[c];
    // cell one row up in this column is now complete
    if (r >= 1) begin
      center = old[0];
      up     = (r >= 2) ? old[1] : 1'b1;
      left   = (c > 0) ? col_hist[c-1][1] : 1'b1;
      right  = (c + 1 < cols) ? col_hist[c+1][0] : 1'b1;
      tally_cross(center, up, cur, left, right);
    end
    col_hist[c] = {old[0], cur};
    if (r == rows - 1) begin
      // bottom row: left neighbor's right side just arrived
      if (c >= 1) begin
        center = row_hist[0];
        left   = (c >= 2) ? row_hist[1] : 1'b1;
        up     = (r >= 1) ? col_hist[c-1][1] : 1'b1;
        tally_cross(center, up, 1'b1, left, cur);
      end
      if (c == cols - 1) begin
        left = (c >= 1) ? row_hist[0] : 1'b1;
        up   = (r >= 1) ? old[0] : 1'b1;
        tally_cross(cur, up, 1'b1, left, 1'b1);
        cnt = frame_tally;
        restart_frame();
        return 1'b1;
      end
    end
    row_hist = {row_hist[1:0], cur};
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
    end
    pos_row = r;
    pos_col = c;
    return 1'b0;
  endfunction

  initial begin
    error_count     = 0;
    results_checked = 0;
    pending_count   = 0;
  end

  always @(posedge clk) begin : watch
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] want;
    if (!rst_n) begin
      foreach (col_hist[i]) col_hist[i] = '0;
      rows_reg = 8'd1;
      cols_reg = 8'd1;
      restart_frame();
      expected_counts.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ROW_COUNT: rows_reg = cfg_wdata;
          REG_COL_COUNT: cols_reg = cfg_wdata;
          default: ;
        endcase
        restart_frame();
      end
      if (in_valid && in_ready) begin
        if (erode_cell(in_cell_char, cnt))
          expected_counts.push_back(cnt);
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, actual cross_count %0d",
                   $time, out_cross_count);
          error_count++;
        end else begin
          want = expected_counts.pop_front();
          if (out_cross_count !== want) begin
            $display("%0t: cross_count mismatch: expected %0d, actual %0d",
                     $time, want, out_cross_count);
            error_count++;
          end
        end
      end
    end
    pending_count <= expected_counts.size();
  end

endmodule

// ===== tb/sv/cross_erosion_pixel_counter_top_tb.sv =====
// Testbench top for the cross-erosion pixel counter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module cross_erosion_pixel_counter_top_tb;
  import cepc_pkg::*;

  localparam int CLK_HALF      = 6;          // 12 ns period
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 4;          // update stage and output register plus margin
  localparam int HOLD_CYCLES   = 80;         // long receiver hold-off
  localparam int RANDOM_ITEMS  = 1900;
  localparam int LIMIT_NS      = 6_000_000;  // far above the slowest legal run

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [CHAR_W-1:0]    in_cell_char;
  logic                 out_valid;
  logic                 out_ready;
  logic [CNT_W-1:0]     out_cross_count;

  int error_count;
  int pending_count;
  int results_checked;

  rx_mode_t rx_mode;
  bit       gaps_on;      // sender idles between bursts when set
  int       burst_left;
  int       sent_items;
  int       sent_frames;
  int       shapes_used;

  cross_erosion_pixel_counter_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_char    (in_cell_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cross_count (out_cross_count)
  );

  // Scoreboard sits beside the block and only watches its ports
  cross_erosion_pixel_counter_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_char    (in_cell_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cross_count (out_cross_count),
    .error_count     (error_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    #(LIMIT_NS);
    $display("Timeout at %0t with %0d results still expected", $time, pending_count);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver. Runs its own stall pattern; the stimulus process only picks the mode.
  // In hold mode it keeps out_ready low for HOLD_CYCLES once, so that back-to-back
  // one-cell frames pile up and the block has to stall its input.
  initial begin : receiver
    bit         held;
    logic [7:0] pat;
    held      = 1'b0;
    pat       = 8'b1101_0110;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_PATTERN: begin
          pat = {pat[6:0], pat[7]};
          out_ready <= pat[0];
        end
        RX_HOLD: begin
          if (!held) begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            held = 1'b1;
            out_ready <= 1'b1;
          end else begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
        end
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            // occasional longer stall
            out_ready <= 1'b0;
            repeat ($urandom_range(2, 10)) @(posedge clk);
          end else begin
            out_ready <= ($urandom_range(0, 2) != 0);
          end
        end
      endcase
      if (rx_mode != RX_HOLD) held = 1'b0;
    end
  end

  // Character that reads as set with the given percent chance
  function automatic logic [CHAR_W-1:0] pick_char(input int density);
    if ($urandom_range(1, 100) <= density)
      return CHAR_W'($urandom_range(SET_THRESHOLD + 1, 255));
    return CHAR_W'($urandom_range(0, SET_THRESHOLD));
  endfunction

  // Both dimension registers, back to back. Called only with in_valid low.
  task automatic set_frame(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= REG_COL_COUNT;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shapes_used++;
  endtask

  // One cell transfer. Valid is only dropped at the end of a burst, never between
  // two back-to-back cells, so it is not lowered and raised in one step.
  task automatic send_cell(input logic [CHAR_W-1:0] ch);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    in_cell_char <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    sent_items++;
  endtask

  task automatic send_frame(input int cells, input int density);
    for (int i = 0; i < cells; i++) send_cell(pick_char(density));
    sent_frames++;
  endtask

  // Idle the sender and wait for every expected count, then let the pipeline settle.
  // The first edge lets the scoreboard see the last cell transfer.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int          directed_items;
    int          k;
    int          rows_eff;
    int          cols_eff;
    int          n_frames;
    int          phase;
    logic [7:0]  rows_raw;
    logic [7:0]  cols_raw;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_ROW_COUNT;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_cell_char = '0;
    rx_mode      = RX_ALWAYS;
    gaps_on      = 1'b0;
    burst_left   = 0;
    sent_items   = 0;
    sent_frames  = 0;
    shapes_used  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Reset shape is 1x1: every cell is its own frame, all neighbors off-grid.
    // Threshold edges and field extremes.
    send_cell(CHAR_W'(SET_THRESHOLD + 1));
    send_cell(SET_THRESHOLD);
    send_cell(8'hFF);
    send_cell(8'h00);
    drain_results();

    // Zero in both registers acts as one
    set_frame(8'd0, 8'd0);
    send_cell(8'hAA);
    drain_results();

    // 3x3 all set: every cell counts
    set_frame(8'd3, 8'd3);
    repeat (9) send_cell(8'h2B);
    drain_results();

    // Single row, one gap in it
    set_frame(8'd1, 8'd4);
    send_cell(8'h2B);
    send_cell(8'h2A);
    send_cell(8'h55);
    send_cell(8'h80);
    drain_results();

    // Single column
    set_frame(8'd4, 8'd1);
    send_cell(8'h7F);
    send_cell(8'h30);
    send_cell(8'h01);
    send_cell(8'hFE);
    drain_results();

    // Partial frame, then a register write abandons it; the next frame starts clean
    set_frame(8'd2, 8'd2);
    send_cell(8'h00);
    send_cell(8'h00);
    drain_results();
    set_frame(8'd2, 8'd2);
    repeat (4) send_cell(8'h40);
    drain_results();
    directed_items = sent_items;

    // ---- back-pressure: receiver holds off while one-cell frames keep coming ----
    set_frame(8'd1, 8'd1);
    rx_mode <= RX_HOLD;
    repeat (12) send_cell(pick_char(50));
    drain_results();

    // ---- random part ----
    // The first three phases force the largest shapes (raw values past the limit
    // too); after that most shapes are small, with the odd long row or column.
    phase = 0;
    while (sent_items - directed_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin rows_raw = 8'd255; cols_raw = 8'd1;   end
        1: begin rows_raw = 8'd1;   cols_raw = 8'd200; end
        2: begin rows_raw = 8'd2;   cols_raw = 8'd128; end
        default: begin
          k = $urandom_range(0, 19);
          if (k == 0) begin
            rows_raw = 8'($urandom_range(100, 255));
            cols_raw = 8'($urandom_range(0, 2));
          end else if (k == 1) begin
            rows_raw = 8'($urandom_range(0, 2));
            cols_raw = 8'($urandom_range(100, 255));
          end else if (k == 2) begin
            rows_raw = 8'd0;
            cols_raw = 8'd0;
          end else if (k <= 4) begin
            rows_raw = 8'($urandom_range(9, 16));
            cols_raw = 8'($urandom_range(9, 16));
          end else begin
            rows_raw = 8'($urandom_range(1, 8));
            cols_raw = 8'($urandom_range(1, 8));
          end
        end
      endcase
      phase++;
      rows_eff = (rows_raw == 0) ? 1 : (rows_raw > 128) ? 128 : int'(rows_raw);
      cols_eff = (cols_raw == 0) ? 1 : (cols_raw > 128) ? 128 : int'(cols_raw);

      // Flow control for this phase; some phases run without any idling
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      gaps_on    = ($urandom_range(0, 3) != 0);
      burst_left = 0;

      set_frame(rows_raw, cols_raw);
      n_frames = (rows_eff * cols_eff > 64) ? 1 : $urandom_range(1, 4);
      repeat (n_frames) begin
        // Mostly dense frames so crosses actually occur; some sparse or empty
        case ($urandom_range(0, 5))
          0:       send_frame(rows_eff * cols_eff, 100);
          1:       send_frame(rows_eff * cols_eff, 0);
          2:       send_frame(rows_eff * cols_eff, 50);
          3:       send_frame(rows_eff * cols_eff, 75);
          default: send_frame(rows_eff * cols_eff, 92);
        endcase
      end
      // Sometimes leave a frame half done; the next register write drops it
      if (rows_eff * cols_eff > 1 && $urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, (rows_eff * cols_eff > 40) ? 40 : rows_eff * cols_eff - 1))
          send_cell(pick_char(80));
      drain_results();
    end

    gaps_on = 1'b0;
    drain_results();

    $display("Sent %0d cell transfers (%0d directed) in %0d full frames across %0d shapes,",
             sent_items, directed_items, sent_frames, shapes_used);
    $display("from 1x1 up to 128-cell rows and columns; %0d frame counts checked.",
             results_checked);
    if (pending_count != 0)
      $display("%0t: %0d expected frame counts never arrived", $time, pending_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cepc_pkg.sv
hdl/cross_erosion_pixel_counter_top.sv
tb/sv/cross_erosion_pixel_counter_checker.sv
tb/sv/cross_erosion_pixel_counter_top_tb.sv
